// ----- rtl/core/ising_metropolis_flip_top_defines.svh -----
// ----------------------------------------------------------------------------
// ising metropolis flip assertion macros
// shared property wrappers for the block's checkers
// ----------------------------------------------------------------------------
`ifndef ISING_METROPOLIS_FLIP_TOP_DEFINES_SVH
`define ISING_METROPOLIS_FLIP_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define IMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define IMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/imf_pkg.sv -----
// ----------------------------------------------------------------------------
// imf_pkg
// shared widths, codes and types of the ising metropolis flip block
// ----------------------------------------------------------------------------
`default_nettype none

package imf_pkg;

    // field widths
    localparam int COORD_W    = 5;
    localparam int FRAC_W     = 16;
    localparam int DE_W       = 5;
    localparam int ENERGY_W   = 13;
    localparam int MAG_W      = 12;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT_DE4 = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT_DE8 = 1'd1;

    // request kinds
    localparam logic REQ_FLIP  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // energy change is 4 * (aligned neighbours) - 8
    localparam logic [DE_W-1:0] DE_OFFSET = 5'd8;
    // aligned-neighbour counts that give the +4, zero and +8 changes
    localparam logic [2:0] ALIGN_DE4 = 3'd3;
    localparam logic [2:0] ALIGN_ZERO = 3'd2;
    localparam logic [2:0] ALIGN_ALL = 3'd4;

    // site and its four neighbours
    typedef struct packed {
        logic centre;
        logic left;
        logic right;
        logic up;
        logic down;
    } nbr_t;

    // outcome of one request
    typedef struct packed {
        logic                   changed;
        logic signed [DE_W-1:0] delta_e;
        logic                   spin_now;
    } decision_t;

endpackage

`default_nettype wire

// ----- rtl/core/ising_metropolis_flip_top.sv -----
// ----------------------------------------------------------------------------
// ising_metropolis_flip_top: single-site metropolis update and spin write of a 2d ising lattice
// result passes from the request register into the result register, held while stalled
// throughput: one request per cycle unless the result is stalled; lattice read-modify-write in the request stage
// reset: all spins up, totals at the all-up values, thresholds zero, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_flip_top #(
    parameter int SIDE = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_we,
    input  logic [imf_pkg::CFG_ADDR_W-1:0]         cfg_index,
    input  logic [imf_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    // request channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   req_type,
    input  logic [imf_pkg::COORD_W-1:0]            col,
    input  logic [imf_pkg::COORD_W-1:0]            row,
    input  logic                                   spin_up,
    input  logic [imf_pkg::FRAC_W-1:0]             rand_frac,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   accepted,
    output logic signed [imf_pkg::DE_W-1:0]        delta_e,
    output logic                                   spin_now,
    output logic signed [imf_pkg::ENERGY_W-1:0]    energy,
    output logic signed [imf_pkg::MAG_W-1:0]       magnetization
);

    localparam int IDX_W  = $clog2(SIDE);
    localparam int NSITES = SIDE * SIDE;
    localparam logic signed [imf_pkg::ENERGY_W-1:0] ENERGY_RESET =
        imf_pkg::ENERGY_W'(-2 * NSITES);
    localparam logic signed [imf_pkg::MAG_W-1:0] MAG_RESET = imf_pkg::MAG_W'(NSITES);
    localparam logic signed [imf_pkg::MAG_W-1:0] MAG_STEP  = imf_pkg::MAG_W'(2);
    localparam logic [imf_pkg::COORD_W:0] SIDE_EXT = (imf_pkg::COORD_W + 1)'(SIDE);

    logic [imf_pkg::FRAC_W-1:0]  accept_de4_reg;
    logic [imf_pkg::FRAC_W-1:0]  accept_de8_reg;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        s1_type_reg;
    logic [imf_pkg::COORD_W-1:0] s1_col_reg;
    logic [imf_pkg::COORD_W-1:0] s1_row_reg;
    logic                        s1_spin_reg;
    logic [imf_pkg::FRAC_W-1:0]  s1_rand_reg;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic                                 accepted_reg;
    logic signed [imf_pkg::DE_W-1:0]      delta_e_reg;
    logic                                 spin_now_reg;
    logic signed [imf_pkg::ENERGY_W-1:0]  energy_reg;
    logic signed [imf_pkg::ENERGY_W-1:0]  energy_next;
    logic signed [imf_pkg::MAG_W-1:0]     magnet_reg;
    logic signed [imf_pkg::MAG_W-1:0]     magnet_next;

    logic                 advance;
    logic                 fire;
    logic                 in_range;
    imf_pkg::nbr_t        nbr;
    imf_pkg::decision_t   dec;

    // handshake
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_de4_reg <= '0;
            accept_de8_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imf_pkg::REG_ACCEPT_DE4: accept_de4_reg <= cfg_wdata;
                imf_pkg::REG_ACCEPT_DE8: accept_de8_reg <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    // request register
    always_comb
    begin
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_type_reg <= req_type;
            s1_col_reg  <= col;
            s1_row_reg  <= row;
            s1_spin_reg <= spin_up;
            s1_rand_reg <= rand_frac;
        end
    end

    // site check
    assign in_range = ({1'b0, s1_col_reg} < SIDE_EXT) && ({1'b0, s1_row_reg} < SIDE_EXT);

    imf_lattice #(
        .SIDE (SIDE)
    ) u_lattice (
        .clk     (clk),
        .rst_n   (rst_n),
        .row     (s1_row_reg[IDX_W-1:0]),
        .col     (s1_col_reg[IDX_W-1:0]),
        .wr_en   (fire && dec.changed),
        .wr_spin (dec.spin_now),
        .nbr     (nbr)
    );

    imf_decide u_decide (
        .in_range   (in_range),
        .req_type   (s1_type_reg),
        .spin_up    (s1_spin_reg),
        .rand_frac  (s1_rand_reg),
        .accept_de4 (accept_de4_reg),
        .accept_de8 (accept_de8_reg),
        .nbr        (nbr),
        .dec        (dec)
    );

    // running totals
    always_comb
    begin
        energy_next = energy_reg;
        magnet_next = magnet_reg;
        if (fire && dec.changed)
        begin
            energy_next = energy_reg + imf_pkg::ENERGY_W'(dec.delta_e);
            magnet_next = dec.spin_now ? magnet_reg + MAG_STEP : magnet_reg - MAG_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= ENERGY_RESET;
            magnet_reg <= MAG_RESET;
        end
        else
        begin
            energy_reg <= energy_next;
            magnet_reg <= magnet_next;
        end
    end

    // result register
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            accepted_reg <= dec.changed;
            delta_e_reg  <= dec.delta_e;
            spin_now_reg <= dec.spin_now;
        end
    end

    // totals shown with the result they belong to
    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign delta_e       = delta_e_reg;
    assign spin_now      = spin_now_reg;
    assign energy        = energy_reg;
    assign magnetization = magnet_reg;

endmodule

`default_nettype wire

// ----- rtl/core/imf_lattice.sv -----
// ----------------------------------------------------------------------------
// imf_lattice
// spin store with periodic neighbour read and single-site write
// ----------------------------------------------------------------------------
`default_nettype none

module imf_lattice #(
    parameter int SIDE = 32,
    localparam int IDX_W = $clog2(SIDE)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  row,
    input  logic [IDX_W-1:0]  col,
    input  logic              wr_en,
    input  logic              wr_spin,
    output imf_pkg::nbr_t     nbr
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(SIDE - 1);

    logic [SIDE-1:0]  lattice_reg [SIDE];
    logic [IDX_W-1:0] left_col;
    logic [IDX_W-1:0] right_col;
    logic [IDX_W-1:0] up_row;
    logic [IDX_W-1:0] down_row;

    // periodic wrap of the neighbour coordinates
    always_comb
    begin
        left_col  = (col == '0)   ? LAST : col - 1'b1;
        right_col = (col == LAST) ? '0   : col + 1'b1;
        up_row    = (row == '0)   ? LAST : row - 1'b1;
        down_row  = (row == LAST) ? '0   : row + 1'b1;
    end

    // neighbour read
    always_comb
    begin
        nbr.centre = lattice_reg[row][col];
        nbr.left   = lattice_reg[row][left_col];
        nbr.right  = lattice_reg[row][right_col];
        nbr.up     = lattice_reg[up_row][col];
        nbr.down   = lattice_reg[down_row][col];
    end

    // spin store, all up after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SIDE; r++)
            begin
                lattice_reg[r] <= '1;
            end
        end
        else if (wr_en)
        begin
            lattice_reg[row][col] <= wr_spin;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/imf_decide.sv -----
// ----------------------------------------------------------------------------
// imf_decide
// energy change and acceptance decision for one request
// ----------------------------------------------------------------------------
`default_nettype none

module imf_decide (
    input  logic                          in_range,
    input  logic                          req_type,
    input  logic                          spin_up,
    input  logic [imf_pkg::FRAC_W-1:0]    rand_frac,
    input  logic [imf_pkg::FRAC_W-1:0]    accept_de4,
    input  logic [imf_pkg::FRAC_W-1:0]    accept_de8,
    input  imf_pkg::nbr_t                 nbr,
    output imf_pkg::decision_t            dec
);

    logic [2:0]                       up_count;
    logic [2:0]                       aligned;
    logic [imf_pkg::DE_W-1:0]         de_raw;
    logic                             flip_ok;
    logic                             changed;

    // count of neighbours aligned with the centre spin
    always_comb
    begin
        up_count = 3'(nbr.left) + 3'(nbr.right) + 3'(nbr.up) + 3'(nbr.down);
        aligned  = nbr.centre ? up_count : imf_pkg::ALIGN_ALL - up_count;
        de_raw   = {aligned, 2'b00} - imf_pkg::DE_OFFSET;
    end

    // metropolis test
    always_comb
    begin
        if (aligned <= imf_pkg::ALIGN_ZERO)
        begin
            flip_ok = 1'b1;
        end
        else if (aligned == imf_pkg::ALIGN_DE4)
        begin
            flip_ok = (rand_frac <= accept_de4);
        end
        else
        begin
            flip_ok = (rand_frac <= accept_de8);
        end
    end

    // outcome, with writes of the held value and off-lattice sites as no-ops
    always_comb
    begin
        case (req_type)
            imf_pkg::REQ_FLIP:  changed = flip_ok;
            imf_pkg::REQ_WRITE: changed = (nbr.centre != spin_up);
            default:            changed = 1'b0;
        endcase
        dec.changed  = in_range && changed;
        dec.delta_e  = (in_range && (req_type == imf_pkg::REQ_FLIP || changed))
                       ? $signed(de_raw) : '0;
        dec.spin_now = in_range && (nbr.centre ^ changed);
    end

endmodule

`default_nettype wire

// ----- rtl/core/imf_checker.sv -----
// ----------------------------------------------------------------------------
// imf_checker
// port-level checks of stalled results and running totals
// ----------------------------------------------------------------------------
`default_nettype none

`include "ising_metropolis_flip_top_defines.svh"

module imf_checker #(
    parameter int SIDE = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic                                   accepted,
    input  logic signed [imf_pkg::DE_W-1:0]        delta_e,
    input  logic                                   spin_now,
    input  logic signed [imf_pkg::ENERGY_W-1:0]    energy,
    input  logic signed [imf_pkg::MAG_W-1:0]       magnetization
);

    localparam int NSITES = SIDE * SIDE;
    localparam logic signed [imf_pkg::ENERGY_W-1:0] ENERGY_RESET =
        imf_pkg::ENERGY_W'(-2 * NSITES);
    localparam logic signed [imf_pkg::MAG_W-1:0] MAG_RESET = imf_pkg::MAG_W'(NSITES);
    localparam logic signed [imf_pkg::MAG_W-1:0] MAG_STEP  = imf_pkg::MAG_W'(2);

    logic signed [imf_pkg::ENERGY_W-1:0] last_e_reg;
    logic signed [imf_pkg::MAG_W-1:0]    last_m_reg;
    logic                                take;

    assign take = out_valid && out_ready;

    // totals of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_e_reg <= ENERGY_RESET;
            last_m_reg <= MAG_RESET;
        end
        else if (take)
        begin
            last_e_reg <= energy;
            last_m_reg <= magnetization;
        end
    end

    // totals hold across a result with no spin change
    `IMF_ASSERT_NOW(a_totals_hold, take && !accepted, (energy == last_e_reg) && (magnetization == last_m_reg), "totals moved without a spin change")

    // totals move by the reported change on a spin change
    `IMF_ASSERT_NOW(a_totals_step, take && accepted, (energy == last_e_reg + imf_pkg::ENERGY_W'(delta_e)) && (magnetization == (spin_now ? last_m_reg + MAG_STEP : last_m_reg - MAG_STEP)), "totals do not follow the spin change")

    // a stalled result holds
    `IMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(accepted) && $stable(delta_e) && $stable(energy) && $stable(magnetization), "stalled result changed")

endmodule

bind ising_metropolis_flip_top imf_checker #(.SIDE(SIDE)) u_imf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .delta_e       (delta_e),
    .spin_now      (spin_now),
    .energy        (energy),
    .magnetization (magnetization)
);

`default_nettype wire
